// ===== rtl/core/wrcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcs_pkg: shared types and constants of the watch read scheduler
// Sizes of the watch maps, the read list and the write FIFO, the function
// and status codes, and the structs passed between front and back.
// ----------------------------------------------------------------------------
package wrcs_pkg;

   // Field widths of the request and response words.
   localparam int FUNC_W   = 3;
   localparam int MSPACE_W = 3;
   localparam int ADDR_W   = 16;
   localparam int CNT_W    = 7;
   localparam int PRIO_W   = 8;
   localparam int LEN_W    = 13;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 3;

   // Watch maps: one per readable space, stored as rows of 64 bits.
   localparam int MAP_BITS        = 4096;
   localparam int MAP_ADDR_W      = $clog2(MAP_BITS);
   localparam int SPACES          = 4;
   localparam int SPACE_W         = $clog2(SPACES);
   localparam int WORD_BITS       = 64;
   localparam int BIT_W           = $clog2(WORD_BITS);
   localparam int WORDS_PER_SPACE = MAP_BITS / WORD_BITS;
   localparam int WPS_W           = $clog2(WORDS_PER_SPACE);
   localparam int ROWS            = SPACES * WORDS_PER_SPACE;
   localparam int ROW_W           = $clog2(ROWS);
   localparam int RANGE_W         = ADDR_W + 1;

   // A byte range may touch this many map rows.
   localparam int MAX_COUNT  = (1 << CNT_W) - 1;
   localparam int MASK_WORDS = (MAX_COUNT + WORD_BITS - 2) / WORD_BITS + 1;
   localparam int MASK_BITS  = MASK_WORDS * WORD_BITS;
   localparam int PART_W     = $clog2(MASK_WORDS);

   // Read list and write FIFO.
   localparam int READ_SLOTS  = 256;
   localparam int RL_IDX_W    = $clog2(READ_SLOTS);
   localparam int RL_CNT_W    = RL_IDX_W + 1;
   localparam int RL_ENTRY_W  = SPACE_W + ADDR_W + LEN_W;
   localparam int WRITE_SLOTS = 16;
   localparam int WF_IDX_W    = $clog2(WRITE_SLOTS);
   localparam int WF_CNT_W    = WF_IDX_W + 1;
   localparam int WF_ENTRY_W  = MSPACE_W + ADDR_W + CNT_W;

   // Function codes.
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SCHED  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_POST   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_POLL   = 3'd5;

   // Memory space codes.
   localparam logic [MSPACE_W-1:0] SPACE_USER = 3'd3;
   localparam logic [MSPACE_W-1:0] SPACE_TIME = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

   // Operation kinds after classification.
   localparam logic [KIND_W-1:0] OP_NOP    = 3'd0;
   localparam logic [KIND_W-1:0] OP_ADD    = 3'd1;
   localparam logic [KIND_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [KIND_W-1:0] OP_SCHED  = 3'd3;
   localparam logic [KIND_W-1:0] OP_CLEAR  = 3'd4;
   localparam logic [KIND_W-1:0] OP_POST   = 3'd5;
   localparam logic [KIND_W-1:0] OP_POLL   = 3'd6;

   // Classified operation held in the queue.
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic [MSPACE_W-1:0] space;
      logic [ADDR_W-1:0]   addr;
      logic [CNT_W-1:0]    count;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_out_type;

   typedef struct packed {
      logic pop;
      logic busy;
   } back_ctl_type;

   typedef struct packed {
      logic [LEN_W-1:0] max_run_length;
      logic [LEN_W-1:0] max_hole;
   } cfg_type;

endpackage

// ===== rtl/core/watch_read_coalescing_scheduler_top.sv =====
`timescale 1ns / 1ps
// Operations: add/remove do a read-modify-write per touched 64-bit map row; clear
// sweeps every row of the maps.
// Schedule: one map bit a cycle, after a read of each row, and a flush per space.
// Throughput: a new word every cycle for no-op and post while the response is not
// stalled; a two-word queue takes requests while the engine works.
// Reset: a clearing pass sweeps all 256 map rows; requests stall until it ends.
// ----------------------------------------------------------------------------
// watch_read_coalescing_scheduler_top: watch read scheduler
// Holds the run-length and hole registers and joins the request front end
// to the operation engine.
// ----------------------------------------------------------------------------
module watch_read_coalescing_scheduler_top import wrcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [LEN_W-1:0]    csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [MSPACE_W-1:0] req_mem_space,
   input  logic [ADDR_W-1:0]   req_start_address,
   input  logic [CNT_W-1:0]    req_byte_count,
   input  logic [PRIO_W-1:0]   req_watch_priority,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_cmd_valid,
   output logic                rsp_cmd_is_write,
   output logic [MSPACE_W-1:0] rsp_cmd_space,
   output logic [ADDR_W-1:0]   rsp_cmd_address,
   output logic [LEN_W-1:0]    rsp_cmd_length,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam logic CSR_MAX_RUN = 1'b0;
   localparam logic CSR_MAX_HOLE = 1'b1;

   cfg_type       cfg_ff, cfg_in;
   queue_out_type q_link;
   back_ctl_type  back_ctl;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_RUN:  cfg_in.max_run_length = csr_wdata;
            CSR_MAX_HOLE: cfg_in.max_hole = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_run_length <= LEN_W'(64);
         cfg_ff.max_hole       <= LEN_W'(8);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request intake.
   wrcs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_mem_space      (req_mem_space),
      .req_start_address  (req_start_address),
      .req_byte_count     (req_byte_count),
      .req_watch_priority (req_watch_priority),
      .q_out              (q_link),
      .back_ctl           (back_ctl)
   );

   // Operation engine.
   wrcs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_in             (q_link),
      .back_ctl         (back_ctl),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cmd_valid    (rsp_cmd_valid),
      .rsp_cmd_is_write (rsp_cmd_is_write),
      .rsp_cmd_space    (rsp_cmd_space),
      .rsp_cmd_address  (rsp_cmd_address),
      .rsp_cmd_length   (rsp_cmd_length),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== rtl/core/wrcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcs_front: request intake and classification
// Decodes each request word, settles the cases that change nothing, and
// holds classified operations in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wrcs_front import wrcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [MSPACE_W-1:0] req_mem_space,
   input  logic [ADDR_W-1:0]   req_start_address,
   input  logic [CNT_W-1:0]    req_byte_count,
   input  logic [PRIO_W-1:0]   req_watch_priority,
   output queue_out_type       q_out,
   input  back_ctl_type        back_ctl
);

   op_type     op_in;
   op_type     q_op_ff [2];
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       head_ff, head_in;
   logic       push;
   logic       range_bad;

   // Range check on the end of the byte range.
   assign range_bad = ({1'b0, req_start_address} + RANGE_W'(req_byte_count))
                      > RANGE_W'(MAP_BITS);

   // Classify the request word.
   always_comb begin
      op_in        = '0;
      op_in.space  = req_mem_space;
      op_in.addr   = req_start_address;
      op_in.count  = req_byte_count;
      op_in.kind   = OP_NOP;
      op_in.status = ST_OK;
      unique case (req_func) inside
         FUNC_ADD, FUNC_REMOVE: begin
            if (req_mem_space > SPACE_USER ||
                (req_func == FUNC_ADD && req_watch_priority == '0)) begin
               op_in.status = ST_IGNORED;
            end else if (range_bad) begin
               op_in.status = ST_RANGE;
            end else if (req_byte_count != '0) begin
               op_in.kind = (req_func == FUNC_ADD) ? OP_ADD : OP_REMOVE;
            end
         end
         FUNC_SCHED: op_in.kind = OP_SCHED;
         FUNC_CLEAR: op_in.kind = OP_CLEAR;
         FUNC_POST: begin
            if (req_mem_space > SPACE_TIME) begin
               op_in.status = ST_IGNORED;
            end else begin
               op_in.kind = OP_POST;
            end
         end
         FUNC_POLL: op_in.kind = OP_POLL;
         default:   op_in.status = ST_IGNORED;
      endcase
   end

   // Queue control.
   assign req_stall   = (q_cnt_ff == 2'd2) || back_ctl.busy;
   assign push        = req_valid && !req_stall;
   assign q_out.valid = (q_cnt_ff != 2'd0);
   assign q_out.op    = q_op_ff[head_ff];

   always_comb begin
      q_cnt_in = q_cnt_ff;
      head_in  = head_ff;
      if (back_ctl.pop) begin
         head_in = ~head_ff;
      end
      case ({push, back_ctl.pop})
         2'b10:   q_cnt_in = q_cnt_ff + 2'd1;
         2'b01:   q_cnt_in = q_cnt_ff - 2'd1;
         default: q_cnt_in = q_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         head_ff  <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         head_ff  <= head_in;
      end
   end

   // Queue storage; the tail sits one past the head when one word is held.
   always_ff @(posedge clock) begin
      if (push) begin
         q_op_ff[head_ff ^ q_cnt_ff[0]] <= op_in;
      end
   end

endmodule

// ===== rtl/core/wrcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcs_back: operation engine
// Owns the watch map memory, the read list and the write FIFO. Edits map
// rows, sweeps the maps clear, scans them bit by bit into read runs and
// answers polls through a response register.
// ----------------------------------------------------------------------------
module wrcs_back import wrcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  queue_out_type       q_in,
   output back_ctl_type        back_ctl,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_cmd_valid,
   output logic                rsp_cmd_is_write,
   output logic [MSPACE_W-1:0] rsp_cmd_space,
   output logic [ADDR_W-1:0]   rsp_cmd_address,
   output logic [LEN_W-1:0]    rsp_cmd_length,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CLR       = 4'd1;
   localparam logic [3:0] S_MOD_RD    = 4'd2;
   localparam logic [3:0] S_MOD_WR    = 4'd3;
   localparam logic [3:0] S_SCH_RD    = 4'd4;
   localparam logic [3:0] S_SCH_BIT   = 4'd5;
   localparam logic [3:0] S_SCH_FLUSH = 4'd6;
   localparam logic [3:0] S_POLL_RD   = 4'd7;

   logic [3:0]           state_ff, state_in;
   op_type               op_ff, op_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [PART_W-1:0]    part_ff, part_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic                 init_ff, init_in;

   logic [RL_CNT_W-1:0]   rl_cnt_ff, rl_cnt_in;
   logic [RL_IDX_W-1:0]   cursor_ff, cursor_in;
   logic [WF_CNT_W-1:0]   wf_cnt_ff, wf_cnt_in;
   logic [WF_IDX_W-1:0]   wf_head_ff, wf_head_in;
   logic [WF_IDX_W-1:0]   wf_tail_ff, wf_tail_in;

   logic                  started_ff, started_in;
   logic [MAP_ADDR_W-1:0] start_ff, start_in;
   logic [MAP_ADDR_W-1:0] stop_ff, stop_in;
   logic [LEN_W-1:0]      holes_ff, holes_in;
   logic                  dropped_ff, dropped_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_cmd_valid_ff, rsp_cmd_valid_in;
   logic                  rsp_is_write_ff, rsp_is_write_in;
   logic [MSPACE_W-1:0]   rsp_space_ff, rsp_space_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_load;

   // Memories and their ports.
   logic [WORD_BITS-1:0]  bm_mem [ROWS];
   logic [WORD_BITS-1:0]  bm_q_ff;
   logic                  bm_we, bm_re;
   logic [ROW_W-1:0]      bm_waddr, bm_raddr;
   logic [WORD_BITS-1:0]  bm_wdata;

   logic [RL_ENTRY_W-1:0] rl_mem [READ_SLOTS];
   logic [RL_ENTRY_W-1:0] rl_q_ff;
   logic                  rl_we, rl_re;
   logic [RL_IDX_W-1:0]   rl_waddr;
   logic [RL_ENTRY_W-1:0] rl_wdata;

   logic [WF_ENTRY_W-1:0] wf_mem [WRITE_SLOTS];
   logic                  wf_we;
   logic [WF_ENTRY_W-1:0] wf_head_word;

   // Scan helpers.
   logic                  emit_en;
   logic                  drop_now;
   logic [MAP_ADDR_W-1:0] emit_start, emit_stop;
   logic [MAP_ADDR_W-1:0] bit_pos;
   logic [LEN_W-1:0]      span, lim, hole_lim, holes_next;
   logic                  cur_bit;
   logic                  can_pop;
   logic [RL_CNT_W-1:0]   cursor_next;
   logic [WORD_BITS-1:0]  mod_mask;
   logic [MASK_BITS-1:0]  base_mask;
   logic [PART_W-1:0]     part_next;

   assign lim      = (cfg.max_run_length == '0) ? LEN_W'(1) : cfg.max_run_length;
   assign hole_lim = (cfg.max_hole == '0) ? LEN_W'(1) : cfg.max_hole;
   assign bit_pos  = {row_ff[WPS_W-1:0], bit_ff};
   assign cur_bit  = bm_q_ff[bit_ff];
   assign span     = LEN_W'(bit_pos - start_ff) + LEN_W'(1);
   assign holes_next = holes_ff + LEN_W'(1);
   assign drop_now = emit_en && rl_cnt_ff[RL_CNT_W-1];
   assign cursor_next = {1'b0, cursor_ff} + RL_CNT_W'(1);
   assign mod_mask = mask_ff[part_ff * WORD_BITS +: WORD_BITS];
   assign part_next = part_ff + PART_W'(1);
   assign base_mask = (MASK_BITS'(1) << q_in.op.count) - MASK_BITS'(1);
   assign wf_head_word = wf_mem[wf_head_ff];

   assign can_pop = (state_ff == S_IDLE) && !init_ff && q_in.valid &&
                    (!rsp_valid_ff || !rsp_stall);
   assign back_ctl.pop  = can_pop;
   assign back_ctl.busy = init_ff;

   // Main control.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      row_in     = row_ff;
      bit_in     = bit_ff;
      part_in    = part_ff;
      mask_in    = mask_ff;
      init_in    = init_ff;
      rl_cnt_in  = rl_cnt_ff;
      cursor_in  = cursor_ff;
      wf_cnt_in  = wf_cnt_ff;
      wf_head_in = wf_head_ff;
      wf_tail_in = wf_tail_ff;
      started_in = started_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      holes_in   = holes_ff;
      dropped_in = dropped_ff;

      bm_we    = 1'b0;
      bm_re    = 1'b0;
      bm_waddr = row_ff;
      bm_raddr = row_ff;
      bm_wdata = '0;
      rl_re    = 1'b0;
      wf_we    = 1'b0;
      emit_en    = 1'b0;
      emit_start = start_ff;
      emit_stop  = stop_ff;

      rsp_load         = 1'b0;
      rsp_cmd_valid_in = 1'b0;
      rsp_is_write_in  = 1'b0;
      rsp_space_in     = '0;
      rsp_addr_in      = '0;
      rsp_len_in       = '0;
      rsp_status_in    = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (can_pop) begin
               op_in = q_in.op;
               unique case (q_in.op.kind) inside
                  OP_ADD, OP_REMOVE: begin
                     row_in  = {q_in.op.space[SPACE_W-1:0],
                                q_in.op.addr[MAP_ADDR_W-1:BIT_W]};
                     mask_in = base_mask << q_in.op.addr[BIT_W-1:0];
                     part_in = '0;
                     state_in = S_MOD_RD;
                  end
                  OP_SCHED: begin
                     rl_cnt_in  = '0;
                     cursor_in  = '0;
                     row_in     = '0;
                     started_in = 1'b0;
                     dropped_in = 1'b0;
                     state_in   = S_SCH_RD;
                  end
                  OP_CLEAR: begin
                     rl_cnt_in = '0;
                     cursor_in = '0;
                     row_in    = '0;
                     state_in  = S_CLR;
                  end
                  OP_POST: begin
                     rsp_load = 1'b1;
                     if (wf_cnt_ff[WF_CNT_W-1]) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wf_we      = 1'b1;
                        wf_tail_in = wf_tail_ff + WF_IDX_W'(1);
                        wf_cnt_in  = wf_cnt_ff + WF_CNT_W'(1);
                     end
                  end
                  OP_POLL: begin
                     rl_re    = 1'b1;
                     state_in = S_POLL_RD;
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = q_in.op.status;
                  end
               endcase
            end
         end

         // Sweep every map row to zero.
         S_CLR: begin
            bm_we  = 1'b1;
            row_in = row_ff + ROW_W'(1);
            if (row_ff == '1) begin
               init_in  = 1'b0;
               rsp_load = !init_ff;
               state_in = S_IDLE;
            end
         end

         S_MOD_RD: begin
            bm_re    = 1'b1;
            state_in = S_MOD_WR;
         end

         // Read-modify-write of one map row.
         S_MOD_WR: begin
            bm_we    = 1'b1;
            bm_wdata = (op_ff.kind == OP_ADD) ? (bm_q_ff | mod_mask)
                                              : (bm_q_ff & ~mod_mask);
            if (part_ff != PART_W'(MASK_WORDS - 1) &&
                mask_ff[part_next * WORD_BITS +: WORD_BITS] != '0) begin
               part_in  = part_next;
               row_in   = row_ff + ROW_W'(1);
               state_in = S_MOD_RD;
            end else begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_SCH_RD: begin
            bm_re    = 1'b1;
            bit_in   = '0;
            state_in = S_SCH_BIT;
         end

         // One map bit per cycle through the run builder.
         S_SCH_BIT: begin
            if (cur_bit) begin
               holes_in = '0;
               stop_in  = bit_pos;
               if (!started_ff) begin
                  started_in = 1'b1;
                  start_in   = bit_pos;
               end else if (span > lim) begin
                  emit_en  = 1'b1;
                  start_in = bit_pos;
               end
            end else if (started_ff) begin
               if (holes_next >= hole_lim) begin
                  emit_en    = 1'b1;
                  started_in = 1'b0;
               end else begin
                  holes_in = holes_next;
               end
            end
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == '1) begin
               if (row_ff[WPS_W-1:0] == '1) begin
                  state_in = S_SCH_FLUSH;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  state_in = S_SCH_RD;
               end
            end
         end

         // Close the open run at the end of a space.
         S_SCH_FLUSH: begin
            emit_en    = started_ff;
            started_in = 1'b0;
            if (row_ff == '1) begin
               rsp_load      = 1'b1;
               rsp_status_in = (dropped_ff || drop_now) ? ST_FULL : ST_OK;
               state_in      = S_IDLE;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = S_SCH_RD;
            end
         end

         // Write FIFO first, then the read list entry under the cursor.
         S_POLL_RD: begin
            rsp_load = 1'b1;
            cursor_in = (cursor_next >= rl_cnt_ff) ? '0 : cursor_next[RL_IDX_W-1:0];
            if (wf_cnt_ff != '0) begin
               rsp_cmd_valid_in = 1'b1;
               rsp_is_write_in  = 1'b1;
               {rsp_space_in, rsp_addr_in} = wf_head_word[WF_ENTRY_W-1:CNT_W];
               rsp_len_in = LEN_W'(wf_head_word[CNT_W-1:0]);
               wf_head_in = wf_head_ff + WF_IDX_W'(1);
               wf_cnt_in  = wf_cnt_ff - WF_CNT_W'(1);
            end else if ({1'b0, cursor_ff} < rl_cnt_ff) begin
               rsp_cmd_valid_in = 1'b1;
               rsp_space_in = MSPACE_W'(rl_q_ff[RL_ENTRY_W-1 -: SPACE_W]);
               rsp_addr_in  = rl_q_ff[LEN_W +: ADDR_W];
               rsp_len_in   = rl_q_ff[LEN_W-1:0];
            end
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      // Store a finished run, or note that the list is full.
      rl_we    = 1'b0;
      rl_waddr = rl_cnt_ff[RL_IDX_W-1:0];
      rl_wdata = {row_ff[ROW_W-1 -: SPACE_W], ADDR_W'(emit_start),
                  LEN_W'(emit_stop - emit_start) + LEN_W'(1)};
      if (emit_en) begin
         if (rl_cnt_ff[RL_CNT_W-1]) begin
            dropped_in = 1'b1;
         end else begin
            rl_we     = 1'b1;
            rl_cnt_in = rl_cnt_ff + RL_CNT_W'(1);
         end
      end

      // Response register holds until taken.
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         init_ff      <= 1'b1;
         row_ff       <= '0;
         rl_cnt_ff    <= '0;
         cursor_ff    <= '0;
         wf_cnt_ff    <= '0;
         wf_head_ff   <= '0;
         wf_tail_ff   <= '0;
         started_ff   <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         row_ff       <= row_in;
         rl_cnt_ff    <= rl_cnt_in;
         cursor_ff    <= cursor_in;
         wf_cnt_ff    <= wf_cnt_in;
         wf_head_ff   <= wf_head_in;
         wf_tail_ff   <= wf_tail_in;
         started_ff   <= started_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      bit_ff   <= bit_in;
      part_ff  <= part_in;
      mask_ff  <= mask_in;
      start_ff <= start_in;
      stop_ff  <= stop_in;
      holes_ff <= holes_in;
      if (rsp_load) begin
         rsp_cmd_valid_ff <= rsp_cmd_valid_in;
         rsp_is_write_ff  <= rsp_is_write_in;
         rsp_space_ff     <= rsp_space_in;
         rsp_addr_ff      <= rsp_addr_in;
         rsp_len_ff       <= rsp_len_in;
         rsp_status_ff    <= rsp_status_in;
      end
   end

   // Watch map memory.
   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem[bm_waddr] <= bm_wdata;
      end
      if (bm_re) begin
         bm_q_ff <= bm_mem[bm_raddr];
      end
   end

   // Read list memory.
   always_ff @(posedge clock) begin
      if (rl_we) begin
         rl_mem[rl_waddr] <= rl_wdata;
      end
      if (rl_re) begin
         rl_q_ff <= rl_mem[cursor_ff];
      end
   end

   // Write FIFO storage; the word comes straight from the queue head.
   always_ff @(posedge clock) begin
      if (wf_we) begin
         wf_mem[wf_tail_ff] <= {q_in.op.space, q_in.op.addr, q_in.op.count};
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cmd_valid    = rsp_cmd_valid_ff;
   assign rsp_cmd_is_write = rsp_is_write_ff;
   assign rsp_cmd_space    = rsp_space_ff;
   assign rsp_cmd_address  = rsp_addr_ff;
   assign rsp_cmd_length   = rsp_len_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   // FIFO count never passes its depth.
   a_wf_cnt: assert property (@(posedge clock) disable iff (reset)
      wf_cnt_ff <= WF_CNT_W'(WRITE_SLOTS))
      else $error("write FIFO count past depth");

   // Read list count never passes its depth.
   a_rl_cnt: assert property (@(posedge clock) disable iff (reset)
      rl_cnt_ff <= RL_CNT_W'(READ_SLOTS))
      else $error("read list count past depth");

   // The cursor stays inside the list or rests at zero.
   a_cursor: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == '0 || {1'b0, cursor_ff} < rl_cnt_ff)
      else $error("read cursor outside list");

   // A response is never loaded over one that is still waiting.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten");
`endif

endmodule

// ===== tb/tb_watch_read_coalescing_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_watch_read_coalescing_scheduler_top: self-checking bench of the scheduler
// A queue of request words feeds a clocked driver; a clocked monitor compares
// each response word with the oldest prediction of an in-bench scheduler
// model (watch maps, read list, write FIFO). Several register settings are
// used, with random idle bursts on both channels and one long response hold.
// ----------------------------------------------------------------------------
module tb_watch_read_coalescing_scheduler_top;
   import wrcs_pkg::*;

   // Register indexes and the function codes the block does not know.
   localparam logic       REG_MAX_RUN  = 1'b0;
   localparam logic       REG_MAX_HOLE = 1'b1;
   localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_B = 3'd7;

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [MSPACE_W-1:0] space;
      logic [ADDR_W-1:0]   addr;
      logic [CNT_W-1:0]    count;
      logic [PRIO_W-1:0]   prio;
   } req_word_type;

   typedef struct {
      logic                cmd_valid;
      logic                is_write;
      logic [MSPACE_W-1:0] space;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    len;
      logic [STATUS_W-1:0] status;
   } cmd_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [LEN_W-1:0]    csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [MSPACE_W-1:0] req_mem_space = '0;
   logic [ADDR_W-1:0]   req_start_address = '0;
   logic [CNT_W-1:0]    req_byte_count = '0;
   logic [PRIO_W-1:0]   req_watch_priority = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_cmd_valid;
   logic                rsp_cmd_is_write;
   logic [MSPACE_W-1:0] rsp_cmd_space;
   logic [ADDR_W-1:0]   rsp_cmd_address;
   logic [LEN_W-1:0]    rsp_cmd_length;
   logic [STATUS_W-1:0] rsp_status;

   watch_read_coalescing_scheduler_top i_dut (.*);

   always #5 clock = ~clock;

   // Model state of the scheduler.
   bit           watch_map [SPACES][MAP_BITS];
   cmd_word_type read_list [READ_SLOTS];
   int           read_count;
   int           read_cursor;
   cmd_word_type write_fifo [$];
   int           run_limit = 64;
   int           hole_limit = 8;

   req_word_type pending_words [$];
   cmd_word_type expected_cmds [$];
   req_word_type cur_word;
   int           errors = 0;
   bit           idle_on = 1'b1;
   bit           req_taken = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;
   int           long_hold = 0;
   bit           hold_request = 1'b0;

   // Merge the set bits of one space into read runs; returns 1 if any dropped.
   function automatic bit scan_map(int sp);
      int  lim, hlim, i, first, last, holes;
      bit  started, dropped;
      lim = (run_limit == 0) ? 1 : run_limit;
      hlim = (hole_limit == 0) ? 1 : hole_limit;
      i = 0;
      dropped = 0;
      while (i < MAP_BITS) begin
         started = 0;
         first = 0;
         last = 0;
         holes = 0;
         forever begin
            if (watch_map[sp][i]) begin
               holes = 0;
               if (!started) begin
                  started = 1;
                  first = i;
               end
               if (i - first + 1 > lim) break;
               last = i;
            end else if (started) begin
               holes++;
               if (holes >= hlim) break;
            end
            i++;
            if (i >= MAP_BITS) break;
         end
         if (started) begin
            if (read_count < READ_SLOTS) begin
               read_list[read_count] = '{1'b1, 1'b0, MSPACE_W'(sp), ADDR_W'(first),
                                         LEN_W'(last - first + 1), ST_OK};
               read_count++;
            end else begin
               dropped = 1;
            end
         end
      end
      return dropped;
   endfunction

   // Apply one accepted word to the model and queue the response it causes.
   function automatic void apply_word(req_word_type w);
      cmd_word_type r;
      r = '{1'b0, 1'b0, '0, '0, '0, ST_OK};
      case (w.func)
         FUNC_ADD, FUNC_REMOVE: begin
            if (w.space >= SPACES || (w.func == FUNC_ADD && w.prio == 0))
               r.status = ST_IGNORED;
            else if (int'(w.addr) + int'(w.count) > MAP_BITS)
               r.status = ST_RANGE;
            else
               for (int k = 0; k < w.count; k++)
                  watch_map[w.space][w.addr + k] = (w.func == FUNC_ADD);
         end
         FUNC_SCHED: begin
            read_cursor = 0;
            read_count = 0;
            for (int s = 0; s < SPACES; s++)
               if (scan_map(s)) r.status = ST_FULL;
         end
         FUNC_CLEAR: begin
            read_cursor = 0;
            read_count = 0;
            for (int s = 0; s < SPACES; s++)
               for (int b = 0; b < MAP_BITS; b++) watch_map[s][b] = 0;
         end
         FUNC_POST: begin
            if (w.space > SPACE_TIME)
               r.status = ST_IGNORED;
            else if (write_fifo.size() >= WRITE_SLOTS)
               r.status = ST_FULL;
            else
               write_fifo.push_back('{1'b1, 1'b1, w.space, w.addr, LEN_W'(w.count),
                                      ST_OK});
         end
         FUNC_POLL: begin
            if (write_fifo.size() > 0) begin
               r = write_fifo.pop_front();
            end else if (read_count > 0 && read_cursor < read_count) begin
               r = read_list[read_cursor];
            end
            r.status = ST_OK;
            read_cursor++;
            if (read_cursor >= read_count) read_cursor = 0;
         end
         default: r.status = ST_IGNORED;
      endcase
      expected_cmds.push_back(r);
   endfunction

   // Response check first, then prediction for a request taken at this edge.
   always @(posedge clock) begin
      cmd_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected response word status=%0d", $time, rsp_status);
            errors++;
         end else begin
            e = expected_cmds.pop_front();
            if (rsp_cmd_valid !== e.cmd_valid || rsp_cmd_is_write !== e.is_write ||
                rsp_cmd_space !== e.space || rsp_cmd_address !== e.addr ||
                rsp_cmd_length !== e.len || rsp_status !== e.status) begin
               $display("%0t: mismatch expected v=%0d w=%0d sp=%0d a=%0d l=%0d st=%0d",
                        $time, e.cmd_valid, e.is_write, e.space, e.addr, e.len, e.status);
               $display("%0t:          actual v=%0d w=%0d sp=%0d a=%0d l=%0d st=%0d",
                        $time, rsp_cmd_valid, rsp_cmd_is_write, rsp_cmd_space,
                        rsp_cmd_address, rsp_cmd_length, rsp_status);
               errors++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         apply_word(cur_word);
         req_taken = 1'b1;
      end
   end

   // Request driver with random idle bursts.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 16);
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            cur_word = pending_words.pop_front();
            req_func <= cur_word.func;
            req_mem_space <= cur_word.space;
            req_start_address <= cur_word.addr;
            req_byte_count <= cur_word.count;
            req_watch_priority <= cur_word.prio;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: random bursts plus one long hold on request.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         long_hold = 600;
      end
      if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(logic idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= LEN_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_MAX_RUN) run_limit = value;
      else hole_limit = value;
   endtask

   task automatic queue_word(logic [2:0] f, int s, int a, int c, int p);
      req_word_type w;
      w = '{f, MSPACE_W'(s), ADDR_W'(a), CNT_W'(c), PRIO_W'(p)};
      pending_words.push_back(w);
   endtask

   // Wait until every queued word is taken and answered, then let the block settle.
   task automatic drain;
      while (pending_words.size() > 0 || req_valid || expected_cmds.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random word, mostly within a small window of the maps so runs merge.
   function automatic req_word_type random_word();
      req_word_type w;
      int r;
      r = $urandom_range(0, 999);
      w.space = ($urandom_range(0, 9) == 0) ? MSPACE_W'($urandom_range(4, 7))
                                            : MSPACE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
         0:       w.addr = ADDR_W'($urandom_range(0, 65535));
         1:       w.addr = ADDR_W'($urandom_range(3968, 4095));
         2, 3:    w.addr = ADDR_W'($urandom_range(0, 4095));
         default: w.addr = ADDR_W'($urandom_range(0, 511));
      endcase
      w.count = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 127))
                                            : CNT_W'($urandom_range(1, 64));
      w.prio = ($urandom_range(0, 9) == 0) ? 8'd0 : PRIO_W'($urandom_range(1, 255));
      if (r < 350)      w.func = FUNC_ADD;
      else if (r < 500) w.func = FUNC_REMOVE;
      else if (r < 760) w.func = FUNC_POLL;
      else if (r < 960) w.func = FUNC_POST;
      else if (r < 976) w.func = FUNC_SCHED;
      else if (r < 982) w.func = FUNC_CLEAR;
      else              w.func = $urandom_range(0, 1) ? FUNC_UNUSED_A : FUNC_UNUSED_B;
      return w;
   endfunction

   initial begin
      int runs [5];
      int holes [5];
      runs = '{4096, 64, 0, 3, 1};
      holes = '{4096, 8, 0, 2, 1};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: one-bit runs overflow the read list, FIFO overflow,
      // ignored and out-of-range words, empty polls, clear.
      write_reg(REG_MAX_RUN, 1);
      write_reg(REG_MAX_HOLE, 1);
      queue_word(FUNC_POLL, 0, 0, 0, 0);
      for (int s = 0; s < SPACES; s++) queue_word(FUNC_ADD, s, 4032 * (s % 2), 64, 255);
      queue_word(FUNC_ADD, 0, 100, 64, 1);
      queue_word(FUNC_SCHED, 0, 0, 0, 0);
      queue_word(FUNC_POLL, 0, 0, 0, 0);
      queue_word(FUNC_ADD, 1, 4090, 10, 5);
      queue_word(FUNC_REMOVE, 2, 65535, 127, 0);
      queue_word(FUNC_ADD, 0, 10, 0, 9);
      queue_word(FUNC_ADD, 0, 10, 4, 0);
      queue_word(FUNC_ADD, SPACE_TIME, 10, 4, 9);
      queue_word(FUNC_REMOVE, 7, 10, 4, 9);
      queue_word(FUNC_UNUSED_A, 7, 65535, 127, 255);
      queue_word(FUNC_UNUSED_B, 0, 0, 0, 0);
      queue_word(FUNC_POST, 7, 1, 1, 0);
      for (int k = 0; k < 17; k++)
         queue_word(FUNC_POST, k % 5, 65535 - k, (k == 0) ? 127 : k, 0);
      queue_word(FUNC_CLEAR, 0, 0, 0, 0);
      for (int k = 0; k < 18; k++) queue_word(FUNC_POLL, 0, 0, 0, 0);
      drain();

      // Random phases over several register settings.
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(REG_MAX_RUN, runs[ph]);
         write_reg(REG_MAX_HOLE, holes[ph]);
         if (ph == 4) idle_on = 1'b0;
         if (ph == 1) begin
            hold_request = 1'b1;
            for (int k = 0; k < 40; k++)
               queue_word((k % 2) ? FUNC_POLL : FUNC_POST, 0, k, 1, 0);
         end
         for (int k = 0; k < 360; k++) pending_words.push_back(random_word());
         queue_word(FUNC_SCHED, 0, 0, 0, 0);
         for (int k = 0; k < 12; k++) queue_word(FUNC_POLL, 0, 0, 0, 0);
         drain();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #100ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wrcs_pkg.sv
rtl/core/wrcs_front.sv
rtl/core/wrcs_back.sv
rtl/core/watch_read_coalescing_scheduler_top.sv
tb/tb_watch_read_coalescing_scheduler_top.sv
